// ----- hw/rtl/wpm_pkg.sv -----
package wpm_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  localparam logic [7:0] STAR_CH  = 8'd42;
  localparam logic [7:0] QMARK_CH = 8'd63;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEXT = 1'b1;

  // One item as it travels down the cell chain.
  typedef struct packed {
    logic             valid;
    logic             is_text;
    logic [7:0]       ch;
    logic             last;
    logic             res;       // item yields a result at the far end
    logic             wr_en;
    logic [PTR_W-1:0] wpos;
    logic [LEN_W-1:0] lsc;
    logic [LEN_W-1:0] len;
    logic             matched;
    logic             text_done;
    logic             ovf;
    logic             bit_calc;  // new row bit of the cell to the left
    logic             bit_old;   // row bit of the cell to the left before this item
  } wpm_item_t;

  typedef struct packed {
    logic matched;
    logic text_done;
    logic overflow;
  } wpm_res_t;

endpackage

// ----- hw/rtl/wpm_front.sv -----
module wpm_front
  import wpm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      adv,
  input  logic      in_valid,
  input  logic      cmd,
  input  logic [7:0] ch,
  input  logic      last,
  output wpm_item_t item_out
);

  logic [LEN_W-1:0] len, len_next, len0;
  logic [LEN_W-1:0] lsc, lsc_next, lsc0;
  logic             fresh, fresh_next;
  logic             ovf, ovf_next, ovf0;
  logic             r0, r0_next;
  logic             accept;
  wpm_item_t        item_next;

  assign accept = in_valid && adv;

  always_comb begin
    len0       = fresh ? '0 : len;
    lsc0       = fresh ? '0 : lsc;
    ovf0       = fresh ? 1'b0 : ovf;
    len_next   = len;
    lsc_next   = lsc;
    ovf_next   = ovf;
    fresh_next = fresh;
    r0_next    = r0;

    item_next           = '0;
    item_next.valid     = in_valid;
    item_next.is_text   = (cmd == CMD_TEXT);
    item_next.ch        = ch;
    item_next.last      = last;
    item_next.bit_old   = r0;

    if (cmd == CMD_TEXT) begin
      // Column zero of the row is zero after any character.
      item_next.len       = len;
      item_next.lsc       = lsc;
      item_next.res       = 1'b1;
      item_next.text_done = last;
      item_next.ovf       = ovf;
      item_next.bit_calc  = 1'b0;
      r0_next             = last;
    end else begin
      len_next = len0;
      lsc_next = lsc0;
      ovf_next = ovf0;
      if (len0 < LEN_W'(MAX_PATTERN)) begin
        item_next.wr_en = 1'b1;
        item_next.wpos  = len0[PTR_W-1:0];
        if (ch == STAR_CH && lsc0 == len0) begin
          lsc_next = lsc0 + LEN_W'(1);
        end
        len_next = len0 + LEN_W'(1);
      end else begin
        ovf_next = 1'b1;
      end
      fresh_next          = last;
      r0_next             = 1'b1;
      item_next.len       = len_next;
      item_next.lsc       = lsc_next;
      item_next.res       = last;
      item_next.matched   = (lsc_next == len_next);
      item_next.text_done = 1'b1;
      item_next.ovf       = ovf_next;
      item_next.bit_calc  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
      len            <= '0;
      lsc            <= '0;
      fresh          <= 1'b1;
      ovf            <= 1'b0;
      r0             <= 1'b1;
    end else begin
      if (adv) begin
        item_out <= item_next;
      end
      if (accept) begin
        len   <= len_next;
        lsc   <= lsc_next;
        fresh <= fresh_next;
        ovf   <= ovf_next;
        r0    <= r0_next;
      end
    end
  end

endmodule

// ----- hw/rtl/wpm_cell.sv -----
module wpm_cell
  import wpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic [PTR_W-1:0] pos,
  input  wpm_item_t        item_in,
  output wpm_item_t        item_out
);

  logic [7:0]       pchar;
  logic             rbit, rbit_next, calc;
  logic [LEN_W-1:0] idx;
  wpm_item_t        item_next;

  always_comb begin
    idx       = LEN_W'(pos) + LEN_W'(1);
    calc      = 1'b0;
    rbit_next = (idx <= item_in.lsc);
    item_next = item_in;
    if (item_in.is_text) begin
      if (idx <= item_in.len) begin
        if (pchar == STAR_CH) begin
          calc = rbit | item_in.bit_calc;
        end else if (pchar == QMARK_CH || pchar == item_in.ch) begin
          calc = item_in.bit_old;
        end
      end
      // A finished text puts the row back to its initial value.
      if (!item_in.last) begin
        rbit_next = calc;
      end
      if (idx == item_in.len) begin
        item_next.matched = calc;
      end
    end
    item_next.bit_calc = calc;
    item_next.bit_old  = rbit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_out.valid <= 1'b0;
      rbit           <= 1'b0;
    end else if (adv) begin
      item_out <= item_next;
      if (item_in.valid) begin
        rbit <= rbit_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && item_in.valid && !item_in.is_text && item_in.wr_en && item_in.wpos == pos) begin
      pchar <= item_in.ch;
    end
  end

endmodule

// ----- hw/rtl/wpm_skid.sv -----
module wpm_skid
  import wpm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  wpm_item_t item_in,
  input  logic      out_ready,
  output logic      adv,
  output logic      out_valid,
  output wpm_res_t  out_res
);

  logic     skid_valid;
  wpm_res_t skid_res, push_res;
  logic     push, pop;

  assign adv  = !skid_valid;
  assign push = adv && item_in.valid && item_in.res;
  assign pop  = out_valid && out_ready;

  always_comb begin
    push_res.matched   = item_in.matched;
    push_res.text_done = item_in.text_done;
    push_res.overflow  = item_in.ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_res    <= skid_res;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_res   <= push_res;
        out_valid <= push;
      end
    end else if (push) begin
      skid_res   <= push_res;
      skid_valid <= 1'b1;
    end
  end

endmodule

// ----- hw/rtl/wildcard_pattern_matcher_core.sv -----
// Channel   Dir  Signals                       Contents
// s_axis    in   tvalid tready tdata tuser     tdata: ch; tuser: cmd; tlast: last
//                tlast
// m_axis    out  tvalid tready tdata tuser     tdata: matched; tuser: overflow;
//                tlast                         tlast: text_done
//
// One item is accepted per cycle while the skid register is empty; every
// item passes an input stage, a chain of MAX_PATTERN cells (one per pattern
// position) and the output register.
// Reset is synchronous and empties the chain; the pattern starts out empty.
// A stalled output fills the skid register and then freezes the whole chain.
module wildcard_pattern_matcher_core
  import wpm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] ch
  input  logic       s_axis_tuser,   // [0] cmd
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [0] matched, [7:1] zero
  output logic       m_axis_tuser,   // [0] overflow
  output logic       m_axis_tlast
);

  wpm_item_t chain [0:MAX_PATTERN];
  wpm_res_t  res;
  logic      adv;

  wpm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (s_axis_tvalid),
    .cmd      (s_axis_tuser),
    .ch       (s_axis_tdata),
    .last     (s_axis_tlast),
    .item_out (chain[0])
  );

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    wpm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .pos      (PTR_W'(k)),
      .item_in  (chain[k]),
      .item_out (chain[k+1])
    );
  end

  wpm_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .item_in   (chain[MAX_PATTERN]),
    .out_ready (m_axis_tready),
    .adv       (adv),
    .out_valid (m_axis_tvalid),
    .out_res   (res)
  );

  assign s_axis_tready = adv;
  assign m_axis_tdata  = {7'd0, res.matched};
  assign m_axis_tuser  = res.overflow;
  assign m_axis_tlast  = res.text_done;

endmodule

// ----- hw/rtl/wpm_checker.sv -----
module wpm_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser,
  input logic       m_axis_tlast
);

  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result shown right after reset");

  // The input side only stalls while a result waits at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  // Taking a result always frees room for a new item.
  a_pop_frees: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready)
    else $error("input still stalled after a result was taken");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("stalled result changed");

endmodule

bind wildcard_pattern_matcher_core wpm_checker u_wpm_checker (.*);
